// ===== hw/rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and character mapping
// Group word passed from the byte assembler to the character serializer,
// plus the base64 alphabet lookup.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] CHAR_PAD   = 7'd61;
  localparam logic [6:0] CHAR_PLUS  = 7'd43;
  localparam logic [6:0] CHAR_SLASH = 7'd47;

  localparam logic [1:0] NBYTES_ONE   = 2'd1;
  localparam logic [1:0] NBYTES_TWO   = 2'd2;
  localparam logic [1:0] NBYTES_THREE = 2'd3;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
  } group_t;

  function automatic logic [6:0] enc_char(logic [5:0] v);
    logic [6:0] e;
    e = {1'b0, v};
    if (v < 6'd26) begin
      return e + 7'd65;
    end else if (v < 6'd52) begin
      return e + 7'd71;
    end else if (v < 6'd62) begin
      return e - 7'd4;
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

  function automatic logic [6:0] group_char(group_t g, logic [1:0] idx);
    logic [5:0] slice;
    logic       pad;
    case (idx)
      2'd0:    slice = g.bits[23:18];
      2'd1:    slice = g.bits[17:12];
      2'd2:    slice = g.bits[11:6];
      default: slice = g.bits[5:0];
    endcase
    pad = ((idx == 2'd2) && (g.nbytes == NBYTES_ONE)) ||
          ((idx == 2'd3) && (g.nbytes != NBYTES_THREE));
    return pad ? CHAR_PAD : enc_char(slice);
  endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front: byte assembler
// Collects input bytes into 24-bit groups and pushes a group when it is
// full or when the message ends.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] data_byte
  input  logic               in_tlast,
  output logic               grp_valid,
  input  logic               grp_ready,
  output b64e_pkg::group_t   grp
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        accept;
  logic        emit;

  assign in_tready = grp_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    case (phase_r)
      2'd1: begin
        grp.bits   = {pend_r[15:8], in_tdata, 8'd0};
        grp.nbytes = b64e_pkg::NBYTES_TWO;
      end
      2'd2: begin
        grp.bits   = {pend_r, in_tdata};
        grp.nbytes = b64e_pkg::NBYTES_THREE;
      end
      default: begin
        grp.bits   = {in_tdata, 16'd0};
        grp.nbytes = b64e_pkg::NBYTES_ONE;
      end
    endcase
    grp.last = in_tlast;
    emit     = in_tlast || (grp.nbytes == b64e_pkg::NBYTES_THREE);

    pend_nxt  = pend_r;
    phase_nxt = phase_r;
    if (accept) begin
      if (emit) begin
        pend_nxt  = 16'd0;
        phase_nxt = 2'd0;
      end else begin
        pend_nxt  = grp.bits[23:8];
        phase_nxt = grp.nbytes;
      end
    end
  end

  assign grp_valid = in_tvalid && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 16'd0;
      phase_r <= 2'd0;
    end else begin
      pend_r  <= pend_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue: group queue
// Two-entry first-in first-out buffer between assembler and serializer.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  b64e_pkg::group_t   wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output b64e_pkg::group_t   rd_data
);

  b64e_pkg::group_t mem_r [b64e_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign wr_ready = (count_r != 2'(b64e_pkg::QUEUE_DEPTH));
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back: character serializer
// Takes one group from the queue and sends its four characters, one word
// per cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               grp_valid,
  output logic               grp_ready,
  input  b64e_pkg::group_t   grp,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [6:0] out_char, [7] zero
  output logic               out_tlast
);

  b64e_pkg::group_t cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       vld_r, vld_nxt;
  logic [6:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       advance;

  assign advance   = !vld_r || out_tready;
  assign grp_ready = advance && !busy_r;

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    vld_nxt  = vld_r && !out_tready;
    char_nxt = char_r;
    last_nxt = last_r;
    if (advance) begin
      if (busy_r) begin
        vld_nxt  = 1'b1;
        char_nxt = b64e_pkg::group_char(cur_r, idx_r);
        last_nxt = cur_r.last && (idx_r == 2'd3);
        idx_nxt  = idx_r + 2'd1;
        busy_nxt = (idx_r != 2'd3);
      end else if (grp_valid) begin
        cur_nxt  = grp;
        vld_nxt  = 1'b1;
        char_nxt = b64e_pkg::group_char(grp, 2'd0);
        last_nxt = 1'b0;
        idx_nxt  = 2'd1;
        busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {1'b0, char_r};
  assign out_tlast  = last_r;

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder: padded base64 encoder on byte streams
// Input words carry one raw byte in in_tdata; in_tlast marks the final byte
// of a message. Output words carry one ASCII character in out_tdata[6:0];
// out_tlast marks the final character of the encoded message.
// Every third byte, or a byte with in_tlast, forms a group that is queued
// and sent as four characters, '=' padding a short final group.
// With the serializer idle, the first character of a group passes through the
// queue and the output register before it is valid. Throughput is set by the
// output stage: one character per cycle while the receiver is ready. Input
// accepts one byte per cycle while the two-group queue has room, and keeps
// accepting while a finished character waits at the output.
// Reset clears pending bytes, the queue and the output stage. When the
// receiver stalls, the output word holds, the queue fills, and then
// in_tready drops until a group slot frees up.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast
);

  b64e_pkg::group_t fq_data, qb_data;
  logic fq_valid, fq_ready;
  logic qb_valid, qb_ready;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .grp_valid (fq_valid),
    .grp_ready (fq_ready),
    .grp       (fq_data)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_valid  (qb_valid),
    .grp_ready  (qb_ready),
    .grp        (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/b64_char_checker.sv =====
// ----------------------------------------------------------------------------
// b64_char_checker: character stream scoreboard for the base64 encoder
// Watches both stream channels of the encoder. Every accepted input word is
// run through an independent base64 encoder model that keeps its own pending
// bytes and group phase; the characters it yields queue up and each accepted
// output word is compared against the oldest one, character and last mark.
// ----------------------------------------------------------------------------
module b64_char_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  input  logic       out_tlast,
  output int         mismatches,
  output int         chars_waiting,
  output int         chars_checked
);

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  enc_char_t   expected_chars[$];
  logic [15:0] held_bytes;
  logic [1:0]  held_count;

  function automatic logic [6:0] b64_symbol(input logic [5:0] v);
    return ALPHABET[8 * (63 - int'(v)) +: 7];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic eom);
    logic [23:0] grp;
    int          nb;
    enc_char_t   c;
    case (held_count)
      2'd1: begin
        grp = {held_bytes[15:8], b, 8'h00};
        nb  = 2;
      end
      2'd2: begin
        grp = {held_bytes, b};
        nb  = 3;
      end
      default: begin
        grp = {b, 16'h0000};
        nb  = 1;
      end
    endcase
    if (nb < 3 && !eom) begin
      held_bytes = (nb == 1) ? {b, 8'h00} : {held_bytes[15:8], b};
      held_count = nb[1:0];
      return;
    end
    c.last = 1'b0;
    c.ch   = b64_symbol(grp[23:18]);
    expected_chars = {expected_chars, c};
    c.ch   = b64_symbol(grp[17:12]);
    expected_chars = {expected_chars, c};
    c.ch   = (nb >= 2) ? b64_symbol(grp[11:6]) : b64e_pkg::CHAR_PAD;
    expected_chars = {expected_chars, c};
    c.ch   = (nb == 3) ? b64_symbol(grp[5:0]) : b64e_pkg::CHAR_PAD;
    c.last = eom;
    expected_chars = {expected_chars, c};
    held_bytes = 16'h0000;
    held_count = 2'd0;
  endfunction

  initial begin
    mismatches    = 0;
    chars_waiting = 0;
    chars_checked = 0;
    held_bytes    = 16'h0000;
    held_count    = 2'd0;
  end

  always @(posedge clk) begin
    enc_char_t want;
    if (!rst_n) begin
      held_bytes = 16'h0000;
      held_count = 2'd0;
      expected_chars.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, actual data %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_tdata !== {1'b0, want.ch}) begin
            mismatches++;
            $display("%0t: char mismatch: expected %h, actual %h",
                     $time, {1'b0, want.ch}, out_tdata);
          end
          if (out_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata, in_tlast);
      end
    end
    chars_waiting = expected_chars.size();
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for base64_stream_encoder
// Sends directed messages covering every group remainder and the alphabet
// extremes, then random messages of random length with random idle bursts on
// both sides and one long output stall that backs up the input. A separate
// checker predicts and compares the character stream.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_BYTES = 90;
  localparam int QUIET_TAIL   = 25;
  localparam int LONG_HOLD    = 150;
  localparam int CYCLE_LIMIT  = 50000;
  localparam int DRAIN_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [6:0] out_char, [7] zero
  logic       out_tlast;

  int   mismatches;
  int   chars_waiting;
  int   chars_checked;
  int   cycle_count;
  int   bytes_sent;
  int   msgs_sent;
  bit   gaps_on;
  bit   long_hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  base64_stream_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  b64_char_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .chars_waiting (chars_waiting),
    .chars_checked (chars_checked)
  );

  task automatic send_word(input logic [7:0] d, input logic l);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (l) msgs_sent++;
  endtask

  initial begin : sink
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int len;
    int k;
    bytes_sent    = 0;
    msgs_sent     = 0;
    gaps_on       = 1'b1;
    long_hold_req = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte messages at both extremes
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    // two-byte messages
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
    // full groups: all plus, all slash, all A
    send_word(8'hFB, 1'b0);
    send_word(8'hEF, 1'b0);
    send_word(8'hBE, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
    // full group followed by a one-byte remainder
    send_word(8'h4D, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h6E, 1'b0);
    send_word(8'h61, 1'b1);

    long_hold_req = 1'b1;
    k = 0;
    while (k < RANDOM_BYTES) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if (k >= RANDOM_BYTES - QUIET_TAIL) gaps_on = 1'b0;
        send_word(8'($urandom_range(0, 255)), i == len - 1);
        k++;
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (chars_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d messages (%0d bytes) of every group remainder; %0d characters checked,",
             msgs_sent, bytes_sent, chars_checked);
    $display("with idle bursts on both sides and a %0d-cycle output stall.", LONG_HOLD);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
